// ===== rtl/core/txdr_pkg.sv =====
// ----------------------------------------------------------------------------
// txdr_pkg
// Shared constants, types and helpers for the transmit descriptor ring manager.
// ----------------------------------------------------------------------------
package txdr_pkg;

    // Ring geometry
    localparam int RING_SLOTS   = 64;    // descriptors in use, 2..64
    localparam int BUFFER_BYTES = 4096;  // circular buffer size, 256..4096
    localparam int BUFFER_BASE  = 4096;  // buffer start address, 0..4096

    // Storage and field widths fixed by the interface
    localparam int SLOT_STORE = 64;
    localparam int SLOT_W     = 6;
    localparam int LEN_W      = 12;
    localparam int BYTES_W    = 13;
    localparam int ADDR_W     = 13;
    localparam int COUNT_W    = 7;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED   = 2'd0,
        STATUS_RING_FULL  = 2'd1,
        STATUS_NO_SPACE   = 2'd2,
        STATUS_COMPLETION = 2'd3
    } status_t;

    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_DONE   = 1'b1
    } op_t;

    // Round a byte count up to whole 32-bit words
    function automatic logic [BYTES_W-1:0] round_to_word(input logic [LEN_W-1:0] len);
        logic [BYTES_W-1:0] sum;
        sum = {1'b0, len} + BYTES_W'(3);
        return {sum[BYTES_W-1:2], 2'b00};
    endfunction

    // Advance a ring index with wrap at RING_SLOTS
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

// ===== rtl/core/tx_descriptor_ring_manager.sv =====
// ----------------------------------------------------------------------------
// tx_descriptor_ring_manager
// Bookkeeping for a transmit descriptor ring and its circular byte buffer.
// ----------------------------------------------------------------------------
// Sequence: a completion beat goes from IDLE straight to EMIT; a submit beat
//   goes to CHECK, then through ADD and back to CHECK for each descriptor its
//   sweep reclaims, each reclaim a length read plus an add, and then to EMIT.
// Flow: one beat in flight; s_tready is high only in IDLE, so the next beat
//   waits for EMIT to load the result, which m_tready can hold back.
// Reset: aresetn (synchronous, active low) empties the ring, restores the free
//   count and write address and clears every ready mark; lengths are not cleared.
module tx_descriptor_ring_manager
    import txdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] frame_length, [17:12] done_index, rest zero
    input  logic        s_tuser,   // [0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [14:2] accepted_bytes,
                                   // [20:15] slot_index, [33:21] buffer_address,
                                   // [40:34] reclaimed_count, [41] kick_transmit
);

    typedef enum logic [1:0] {
        ST_IDLE,   // wait for a beat
        ST_CHECK,  // test the drain descriptor, read its length
        ST_ADD,    // return the length to the free count
        ST_EMIT    // hand the result to the output register
    } state_t;

    state_t state_reg;

    // Ring state
    logic [BYTES_W-1:0]    free_bytes_reg;
    logic [ADDR_W-1:0]     write_addr_reg;
    logic [SLOT_W-1:0]     fill_slot_reg;
    logic [SLOT_W-1:0]     drain_slot_reg;
    logic [COUNT_W-1:0]    in_use_reg;
    logic [SLOT_STORE-1:0] slot_ready_reg;

    // Length store: one write port, one registered read port
    logic [LEN_W-1:0] slot_length_mem [SLOT_STORE];
    logic [LEN_W-1:0] rd_len_reg;

    // Pending result fields
    status_t             res_status_reg;
    logic [BYTES_W-1:0]  res_bytes_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    // Input fields
    logic [LEN_W-1:0]  in_len;
    logic [SLOT_W-1:0] in_done;
    op_t               in_op;
    logic              in_accept;

    assign in_len    = s_tdata[11:0];
    assign in_done   = s_tdata[17:12];
    assign in_op     = op_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Admission check and next write address for a submit
    logic [BYTES_W-1:0] asize;
    logic               ring_full;
    logic               no_space;
    logic [ADDR_W-1:0]  offset;
    logic [ADDR_W:0]    addr_sum;
    logic [ADDR_W:0]    addr_wrap;
    logic [ADDR_W-1:0]  write_addr_next;
    logic               submit_ok;
    logic               done_in_ring;

    assign asize     = round_to_word(in_len);
    assign ring_full = (in_use_reg >= COUNT_W'(RING_SLOTS));
    assign no_space  = (asize > free_bytes_reg);
    assign submit_ok = in_accept && (in_op == OP_SUBMIT) && !ring_full && !no_space;
    assign done_in_ring = ({1'b0, in_done} < COUNT_W'(RING_SLOTS));

    assign offset    = (write_addr_reg >= ADDR_W'(BUFFER_BASE))
                       ? write_addr_reg - ADDR_W'(BUFFER_BASE) : '0;
    assign addr_sum  = {1'b0, offset} + {1'b0, asize};
    // offset stays below the buffer size and an admitted asize does not exceed it: one subtract wraps
    assign addr_wrap = (addr_sum >= (ADDR_W+1)'(BUFFER_BYTES))
                       ? addr_sum - (ADDR_W+1)'(BUFFER_BYTES) : addr_sum;
    assign write_addr_next = ADDR_W'(addr_wrap + (ADDR_W+1)'(BUFFER_BASE));

    // Length store: write on an admitted submit, read the drain slot each cycle
    always_ff @(posedge aclk) begin
        if (submit_ok) begin
            slot_length_mem[fill_slot_reg] <= in_len;
        end
        rd_len_reg <= slot_length_mem[drain_slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_bytes_reg <= BYTES_W'(BUFFER_BYTES);
            write_addr_reg <= ADDR_W'(BUFFER_BASE);
            fill_slot_reg  <= '0;
            drain_slot_reg <= '0;
            in_use_reg     <= '0;
            slot_ready_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Drop the output beat once taken; EMIT reloads it on its own
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        res_count_reg <= '0;
                        if (in_op == OP_DONE) begin
                            // Clear the ready mark; out-of-ring indexes are ignored
                            if (done_in_ring) begin
                                slot_ready_reg[in_done] <= 1'b0;
                            end
                            res_status_reg <= STATUS_COMPLETION;
                            res_bytes_reg  <= '0;
                            res_slot_reg   <= '0;
                            res_addr_reg   <= '0;
                            state_reg      <= ST_EMIT;
                        end else begin
                            if (ring_full) begin
                                res_status_reg <= STATUS_RING_FULL;
                                res_bytes_reg  <= '0;
                                res_slot_reg   <= '0;
                                res_addr_reg   <= '0;
                            end else if (no_space) begin
                                res_status_reg <= STATUS_NO_SPACE;
                                res_bytes_reg  <= '0;
                                res_slot_reg   <= '0;
                                res_addr_reg   <= '0;
                            end else begin
                                res_status_reg <= STATUS_ACCEPTED;
                                res_bytes_reg  <= asize;
                                res_slot_reg   <= fill_slot_reg;
                                res_addr_reg   <= write_addr_reg;
                                slot_ready_reg[fill_slot_reg] <= 1'b1;
                                write_addr_reg <= write_addr_next;
                                fill_slot_reg  <= next_slot(fill_slot_reg);
                                in_use_reg     <= in_use_reg + COUNT_W'(1);
                                free_bytes_reg <= free_bytes_reg - asize;
                            end
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK: begin
                    // Stop at an empty ring or the first descriptor still ready
                    if ((in_use_reg == '0) || slot_ready_reg[drain_slot_reg]) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_ADD;
                    end
                end

                ST_ADD: begin
                    free_bytes_reg <= free_bytes_reg + round_to_word(rd_len_reg);
                    drain_slot_reg <= next_slot(drain_slot_reg);
                    in_use_reg     <= in_use_reg - COUNT_W'(1);
                    res_count_reg  <= res_count_reg + COUNT_W'(1);
                    state_reg      <= ST_CHECK;
                end

                ST_EMIT: begin
                    // Load the output register once it is free or being drained
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0,
                                         (in_use_reg != '0),
                                         res_count_reg,
                                         res_addr_reg,
                                         res_slot_reg,
                                         res_bytes_reg,
                                         res_status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
